FILE: rtl/core/cdsr_pkg.sv
// Shared definitions for the byte deque search/replace unit.
// Operation and status codes and the cell control structs; no dependencies.
package cdsr_pkg;

    // operation codes carried in s_axis_tuser
    localparam logic [2:0] KIND_APPEND    = 3'd0;
    localparam logic [2:0] KIND_TAKE_HEAD = 3'd1;
    localparam logic [2:0] KIND_TAKE_TAIL = 3'd2;
    localparam logic [2:0] KIND_PEEK_HEAD = 3'd3;
    localparam logic [2:0] KIND_PEEK_TAIL = 3'd4;
    localparam logic [2:0] KIND_REPLACE   = 3'd5;
    localparam logic [2:0] KIND_REMOVE    = 3'd6;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // operation broadcast to every cell
    typedef struct packed {
        logic       fire;
        logic [2:0] kind;
        logic [7:0] value;
        logic [7:0] replacement;
    } cell_ctl_t;

    // per-cell position relative to the current fill level
    typedef struct packed {
        logic valid;     // cell holds an entry
        logic at_count;  // first free cell
        logic is_tail;   // newest entry
    } cell_pos_t;

endpackage

FILE: rtl/core/char_deque_search_replace_unit.sv
// Top level of the byte deque with search/replace: a chain of entry cells plus
// fill counter and a registered result beat. Depends on cdsr_pkg and cdsr_cell.
//
// Byte deque with append, take/peek at either end, replace-all-by-value and
// remove-first-by-value. Each input beat gives exactly one result beat. The
// unit accepts one beat per clock while the result side keeps taking: the
// operation is applied to the cell chain in the accepting cycle and its result
// lands in the output register in the cycle after. Input ready is low only
// while a result is held and not taken. The clock limit is set by the
// first-match ripple that runs through all DEPTH cells for replace and remove,
// plus the tail select.
// Entry contents are not cleared by reset; only the fill count and the result valid flag are.
module char_deque_search_replace_unit #(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] value, [15:8] replacement
    input  logic [2:0]  s_axis_tuser,   // [2:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] data, [9:8] status, [9+LEN_W:10] length, zero padding above
    output logic [((10 + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata
);
    import cdsr_pkg::*;

    localparam int LEN_W = $clog2(DEPTH + 1);
    localparam int OUT_W = ((10 + LEN_W + 7) / 8) * 8;
    localparam int PAD_W = OUT_W - 10 - LEN_W;

    logic [LEN_W-1:0] count_reg;
    logic [LEN_W-1:0] count_next;
    logic             out_valid_reg;
    logic [7:0]       out_data_reg;
    logic [7:0]       out_data_next;
    logic [1:0]       out_status_reg;
    logic [1:0]       out_status_next;
    logic [LEN_W-1:0] out_len_reg;

    logic             accept;
    logic             empty;
    logic             full;
    logic             found;
    logic [7:0]       tail_sel;

    cell_ctl_t        ctl;
    cell_pos_t        pos       [DEPTH];
    logic [7:0]       cell_data [DEPTH];
    logic [7:0]       cell_tail [DEPTH];
    logic [DEPTH:0]   prefix;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign empty         = (count_reg == '0);
    assign full          = (count_reg == LEN_W'(DEPTH));

    assign ctl.fire        = accept;
    assign ctl.kind        = s_axis_tuser;
    assign ctl.value       = s_axis_tdata[7:0];
    assign ctl.replacement = s_axis_tdata[15:8];

    // cell chain
    assign prefix[0] = 1'b0;
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            assign pos[gi].valid    = (LEN_W'(gi) < count_reg);
            assign pos[gi].at_count = (count_reg == LEN_W'(gi));
            assign pos[gi].is_tail  = (count_reg == LEN_W'(gi + 1));

            cdsr_cell u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .pos        (pos[gi]),
                .nbr_data   (cell_data[(gi + 1 < DEPTH) ? gi + 1 : gi]),
                .prefix_in  (prefix[gi]),
                .data       (cell_data[gi]),
                .tail_data  (cell_tail[gi]),
                .prefix_out (prefix[gi + 1])
            );
        end
    endgenerate

    assign found = prefix[DEPTH];

    // tail byte: only the tail cell drives a nonzero value
    always_comb
    begin
        tail_sel = 8'd0;
        for (int i = 0; i < DEPTH; i++)
            tail_sel = tail_sel | cell_tail[i];
    end

    // result and fill count for the accepted beat
    always_comb
    begin
        count_next      = count_reg;
        out_data_next   = 8'd0;
        out_status_next = ST_OK;
        case (s_axis_tuser)
            KIND_APPEND:
            begin
                if (full)
                    out_status_next = ST_FULL;
                else
                    count_next = count_reg + LEN_W'(1);
            end
            KIND_TAKE_HEAD, KIND_PEEK_HEAD:
            begin
                if (empty)
                    out_status_next = ST_EMPTY;
                else
                begin
                    out_data_next = cell_data[0];
                    if (s_axis_tuser == KIND_TAKE_HEAD)
                        count_next = count_reg - LEN_W'(1);
                end
            end
            KIND_TAKE_TAIL, KIND_PEEK_TAIL:
            begin
                if (empty)
                    out_status_next = ST_EMPTY;
                else
                begin
                    out_data_next = tail_sel;
                    if (s_axis_tuser == KIND_TAKE_TAIL)
                        count_next = count_reg - LEN_W'(1);
                end
            end
            KIND_REPLACE:
            begin
                if (!found)
                    out_status_next = ST_NOTFOUND;
            end
            KIND_REMOVE:
            begin
                if (!found)
                    out_status_next = ST_NOTFOUND;
                else
                    count_next = count_reg - LEN_W'(1);
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg   <= out_data_next;
            out_status_reg <= out_status_next;
            out_len_reg    <= count_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    generate
        if (PAD_W > 0)
        begin : g_pad
            assign m_axis_tdata = {{PAD_W{1'b0}}, out_len_reg, out_status_reg, out_data_reg};
        end
        else
        begin : g_nopad
            assign m_axis_tdata = {out_len_reg, out_status_reg, out_data_reg};
        end
    endgenerate

    // checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LEN_W'(DEPTH))
        else $error("fill count above depth");

    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == ST_FULL) |-> (out_len_reg == LEN_W'(DEPTH)))
        else $error("full status with store not full");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == ST_EMPTY)
            |-> (out_len_reg == '0 && out_data_reg == 8'd0))
        else $error("empty status with entries or data");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !(out_valid_reg && !m_axis_tready))
        else $error("beat accepted over a held result");

endmodule

FILE: rtl/core/cdsr_cell.sv
// One entry cell of the deque chain: holds a byte, matches it, shifts toward head.
// Depends on cdsr_pkg.
module cdsr_cell (
    input  logic               clk,
    input  cdsr_pkg::cell_ctl_t ctl,
    input  cdsr_pkg::cell_pos_t pos,
    input  logic [7:0]         nbr_data,    // data of the next cell toward the tail
    input  logic               prefix_in,   // a match exists closer to the head
    output logic [7:0]         data,
    output logic [7:0]         tail_data,   // data when this is the tail, else zero
    output logic               prefix_out
);
    import cdsr_pkg::*;

    logic [7:0] data_reg;
    logic [7:0] data_next;
    logic       match;

    // match against the broadcast value, ripple the first-match flag
    assign match      = pos.valid && (data_reg == ctl.value);
    assign prefix_out = prefix_in | match;
    assign data       = data_reg;
    assign tail_data  = pos.is_tail ? data_reg : 8'd0;

    // next entry value
    always_comb
    begin
        data_next = data_reg;
        if (ctl.fire)
        begin
            case (ctl.kind)
                KIND_APPEND:
                begin
                    if (pos.at_count)
                        data_next = ctl.value;
                end
                KIND_TAKE_HEAD:
                begin
                    data_next = nbr_data;
                end
                KIND_REPLACE:
                begin
                    if (match)
                        data_next = ctl.replacement;
                end
                KIND_REMOVE:
                begin
                    if (prefix_out)
                        data_next = nbr_data;
                end
                default:
                begin
                    data_next = data_reg;
                end
            endcase
        end
    end

    // entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule
